// ===== rtl/core/mrpt_pkg.sv =====
`timescale 1ns / 1ps
package mrpt_pkg;

	localparam int WIDTH = 64;
	localparam int CNT_W = $clog2(WIDTH);
	localparam int S_W = CNT_W + 1;
	localparam int NUM_SP = 11;
	localparam int SP_W = 5;
	localparam int NUM_BASES = 7;
	localparam int BIDX_W = 3;
	localparam int BASE_W = 31;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TDIV, ST_CHECK, ST_SHIFT, ST_BASE, ST_REDW, ST_BCHK,
		ST_EXP_SQ, ST_EXP_SQW, ST_EXP_MB, ST_EXP_MBW, ST_EXP_NEXT, ST_XCHK,
		ST_RCHK, ST_RSQW, ST_RTEST, ST_NEXTB, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_REDUCE, OP_SQ, OP_XB
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    tdiv_step;
		logic    shift_step;
		logic    mul_start;
		mul_op_t mul_op;
		logic    x_one;
		logic    cnt_init;
		logic    cnt_dec;
		logic    r_init;
		logic    r_inc;
		logic    base_inc;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic n_lt2;
		logic sp_eq;
		logic sp_div;
		logic d_even;
		logic mul_busy;
		logic mul_done;
		logic b_zero;
		logic x_one;
		logic x_nm1;
		logic d_bit;
		logic r_lt_s;
		logic base_last;
	} sts_t;

	function automatic logic [SP_W-1:0] small_prime(input logic [3:0] idx);
		logic [SP_W-1:0] p;
		case (idx)
			4'd0:    p = 5'd2;
			4'd1:    p = 5'd3;
			4'd2:    p = 5'd5;
			4'd3:    p = 5'd7;
			4'd4:    p = 5'd11;
			4'd5:    p = 5'd13;
			4'd6:    p = 5'd17;
			4'd7:    p = 5'd19;
			4'd8:    p = 5'd23;
			4'd9:    p = 5'd29;
			4'd10:   p = 5'd31;
			default: p = 5'd31;
		endcase
		return p;
	endfunction

	function automatic logic [BASE_W-1:0] mr_base(input logic [BIDX_W-1:0] idx);
		logic [BASE_W-1:0] b;
		case (idx)
			3'd0:    b = 31'd2;
			3'd1:    b = 31'd325;
			3'd2:    b = 31'd9375;
			3'd3:    b = 31'd28178;
			3'd4:    b = 31'd450775;
			3'd5:    b = 31'd9780504;
			3'd6:    b = 31'd1795265022;
			default: b = 31'd2;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/mrpt_modmul.sv =====
`timescale 1ns / 1ps
// bit-serial (x * y) mod m, one bit of y per cycle, msb first
module mrpt_modmul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mrpt_pkg::WIDTH-1:0]   x,
	input  logic [mrpt_pkg::WIDTH-1:0]   y,
	input  logic [mrpt_pkg::WIDTH-1:0]   m,
	output logic                         busy,
	output logic                         done,
	output logic [mrpt_pkg::WIDTH-1:0]   prod
);

	logic                         busy_q;
	logic                         done_q;
	logic [mrpt_pkg::CNT_W-1:0]   cnt_q;
	logic [mrpt_pkg::WIDTH-1:0]   acc_q;
	logic [mrpt_pkg::WIDTH-1:0]   x_q;
	logic [mrpt_pkg::WIDTH-1:0]   y_q;
	logic [mrpt_pkg::WIDTH:0]     mw;
	logic [mrpt_pkg::WIDTH:0]     a2;
	logic [mrpt_pkg::WIDTH:0]     t1;
	logic [mrpt_pkg::WIDTH:0]     t2;
	logic [mrpt_pkg::WIDTH:0]     t3;

	always_comb begin
		mw = {1'b0, m};
		a2 = {acc_q, 1'b0};
		t1 = (a2 >= mw) ? a2 - mw : a2;
		t2 = t1 + {1'b0, x_q};
		if (y_q[mrpt_pkg::WIDTH-1]) begin
			t3 = (t2 >= mw) ? t2 - mw : t2;
		end else begin
			t3 = t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mrpt_pkg::CNT_W'(mrpt_pkg::WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= t3[mrpt_pkg::WIDTH-1:0];
			y_q   <= {y_q[mrpt_pkg::WIDTH-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/core/mrpt_datapath.sv =====
`timescale 1ns / 1ps
module mrpt_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mrpt_pkg::WIDTH-1:0]   cand,
	input  mrpt_pkg::cmd_t               cmd,
	output mrpt_pkg::sts_t               sts
);

	logic [mrpt_pkg::WIDTH-1:0]   n_q;
	logic [mrpt_pkg::WIDTH-1:0]   nm1_q;
	logic [mrpt_pkg::WIDTH-1:0]   d_q;
	logic [mrpt_pkg::S_W-1:0]     s_q;
	logic [mrpt_pkg::S_W-1:0]     r_q;
	logic [mrpt_pkg::WIDTH-1:0]   x_q;
	logic [mrpt_pkg::WIDTH-1:0]   b_q;
	logic [mrpt_pkg::CNT_W-1:0]   cnt_q;
	logic [mrpt_pkg::BIDX_W-1:0]  bidx_q;
	logic [mrpt_pkg::SP_W-1:0]    rem_q [mrpt_pkg::NUM_SP];
	mrpt_pkg::mul_op_t            op_q;

	logic [mrpt_pkg::WIDTH-1:0]   mx;
	logic [mrpt_pkg::WIDTH-1:0]   my;
	logic                         m_busy;
	logic                         m_done;
	logic [mrpt_pkg::WIDTH-1:0]   m_prod;
	logic                         sp_eq;
	logic                         sp_div;

	always_comb begin
		case (cmd.mul_op)
			mrpt_pkg::OP_REDUCE: begin
				mx = mrpt_pkg::WIDTH'(1);
				my = mrpt_pkg::WIDTH'(mrpt_pkg::mr_base(bidx_q));
			end
			mrpt_pkg::OP_SQ: begin
				mx = x_q;
				my = x_q;
			end
			mrpt_pkg::OP_XB: begin
				mx = b_q;
				my = x_q;
			end
			default: begin
				mx = x_q;
				my = x_q;
			end
		endcase
	end

	mrpt_modmul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.x     (mx),
		.y     (my),
		.m     (n_q),
		.busy  (m_busy),
		.done  (m_done),
		.prod  (m_prod)
	);

	// serial remainders of n by the small primes, msb first
	always_ff @(posedge clk) begin
		for (int i = 0; i < mrpt_pkg::NUM_SP; i++) begin
			logic [mrpt_pkg::SP_W:0] t;
			t = {rem_q[i], n_q[cnt_q]};
			if (cmd.load) begin
				rem_q[i] <= '0;
			end else if (cmd.tdiv_step) begin
				if (t >= {1'b0, mrpt_pkg::small_prime(4'(i))}) begin
					t = t - {1'b0, mrpt_pkg::small_prime(4'(i))};
				end
				rem_q[i] <= t[mrpt_pkg::SP_W-1:0];
			end
		end
	end

	always_comb begin
		sp_eq  = 1'b0;
		sp_div = 1'b0;
		for (int i = 0; i < mrpt_pkg::NUM_SP; i++) begin
			if (n_q == mrpt_pkg::WIDTH'(mrpt_pkg::small_prime(4'(i)))) sp_eq = 1'b1;
			if (rem_q[i] == '0) sp_div = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= cand;
			nm1_q <= cand - 1'b1;
			d_q   <= cand - 1'b1;
			s_q   <= '0;
		end else if (cmd.shift_step) begin
			d_q <= {1'b0, d_q[mrpt_pkg::WIDTH-1:1]};
			s_q <= s_q + 1'b1;
		end
		if (cmd.mul_start) op_q <= cmd.mul_op;
		if (cmd.x_one) begin
			x_q <= mrpt_pkg::WIDTH'(1);
		end else if (m_done && op_q != mrpt_pkg::OP_REDUCE) begin
			x_q <= m_prod;
		end
		if (m_done && op_q == mrpt_pkg::OP_REDUCE) b_q <= m_prod;
		if (cmd.r_init) begin
			r_q <= mrpt_pkg::S_W'(1);
		end else if (cmd.r_inc) begin
			r_q <= r_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bidx_q <= '0;
		end else begin
			if (cmd.load || cmd.cnt_init) begin
				cnt_q <= mrpt_pkg::CNT_W'(mrpt_pkg::WIDTH - 1);
			end else if (cmd.tdiv_step || cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.load) begin
				bidx_q <= '0;
			end else if (cmd.base_inc) begin
				bidx_q <= bidx_q + 1'b1;
			end
		end
	end

	always_comb begin
		sts.cnt_zero  = (cnt_q == '0);
		sts.n_lt2     = (n_q < mrpt_pkg::WIDTH'(2));
		sts.sp_eq     = sp_eq;
		sts.sp_div    = sp_div;
		sts.d_even    = ~d_q[0];
		sts.mul_busy  = m_busy;
		sts.mul_done  = m_done;
		sts.b_zero    = (b_q == '0);
		sts.x_one     = (x_q == mrpt_pkg::WIDTH'(1));
		sts.x_nm1     = (x_q == nm1_q);
		sts.d_bit     = d_q[cnt_q];
		sts.r_lt_s    = (r_q < s_q);
		sts.base_last = (bidx_q == mrpt_pkg::BIDX_W'(mrpt_pkg::NUM_BASES - 1));
	end

endmodule

// ===== rtl/core/mrpt_ctrl.sv =====
`timescale 1ns / 1ps
module mrpt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            is_prime,
	output mrpt_pkg::cmd_t  cmd,
	input  mrpt_pkg::sts_t  sts
);

	mrpt_pkg::state_t st_q, st_d;
	logic verdict_q;
	logic set_verdict;
	logic verdict_val;
	logic out_valid_q;
	logic is_prime_q;
	logic out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= mrpt_pkg::ST_IDLE;
			verdict_q   <= 1'b0;
			out_valid_q <= 1'b0;
			is_prime_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (set_verdict) verdict_q <= verdict_val;
			if (out_load) begin
				out_valid_q <= 1'b1;
				is_prime_q  <= verdict_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_d        = st_q;
		cmd         = '0;
		cmd.mul_op  = mrpt_pkg::OP_SQ;
		set_verdict = 1'b0;
		verdict_val = 1'b0;
		out_load    = 1'b0;
		in_stall    = (st_q != mrpt_pkg::ST_IDLE);
		case (st_q)
			mrpt_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d = mrpt_pkg::ST_TDIV;
				end
			end
			mrpt_pkg::ST_TDIV: begin
				cmd.tdiv_step = 1'b1;
				if (sts.cnt_zero) st_d = mrpt_pkg::ST_CHECK;
			end
			mrpt_pkg::ST_CHECK: begin
				if (sts.n_lt2 || (!sts.sp_eq && sts.sp_div)) begin
					set_verdict = 1'b1;
					st_d = mrpt_pkg::ST_DONE;
				end else if (sts.sp_eq) begin
					set_verdict = 1'b1;
					verdict_val = 1'b1;
					st_d = mrpt_pkg::ST_DONE;
				end else begin
					st_d = mrpt_pkg::ST_SHIFT;
				end
			end
			mrpt_pkg::ST_SHIFT: begin
				if (sts.d_even) begin
					cmd.shift_step = 1'b1;
				end else begin
					st_d = mrpt_pkg::ST_BASE;
				end
			end
			mrpt_pkg::ST_BASE: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op = mrpt_pkg::OP_REDUCE;
				st_d = mrpt_pkg::ST_REDW;
			end
			mrpt_pkg::ST_REDW: begin
				if (sts.mul_done) st_d = mrpt_pkg::ST_BCHK;
			end
			mrpt_pkg::ST_BCHK: begin
				if (sts.b_zero) begin
					st_d = mrpt_pkg::ST_NEXTB;
				end else begin
					cmd.x_one = 1'b1;
					cmd.cnt_init = 1'b1;
					st_d = mrpt_pkg::ST_EXP_SQ;
				end
			end
			mrpt_pkg::ST_EXP_SQ: begin
				cmd.mul_start = 1'b1;
				st_d = mrpt_pkg::ST_EXP_SQW;
			end
			mrpt_pkg::ST_EXP_SQW: begin
				if (sts.mul_done) st_d = mrpt_pkg::ST_EXP_MB;
			end
			mrpt_pkg::ST_EXP_MB: begin
				if (sts.d_bit) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op = mrpt_pkg::OP_XB;
					st_d = mrpt_pkg::ST_EXP_MBW;
				end else begin
					st_d = mrpt_pkg::ST_EXP_NEXT;
				end
			end
			mrpt_pkg::ST_EXP_MBW: begin
				if (sts.mul_done) st_d = mrpt_pkg::ST_EXP_NEXT;
			end
			mrpt_pkg::ST_EXP_NEXT: begin
				if (sts.cnt_zero) begin
					st_d = mrpt_pkg::ST_XCHK;
				end else begin
					cmd.cnt_dec = 1'b1;
					st_d = mrpt_pkg::ST_EXP_SQ;
				end
			end
			mrpt_pkg::ST_XCHK: begin
				if (sts.x_one || sts.x_nm1) begin
					st_d = mrpt_pkg::ST_NEXTB;
				end else begin
					cmd.r_init = 1'b1;
					st_d = mrpt_pkg::ST_RCHK;
				end
			end
			mrpt_pkg::ST_RCHK: begin
				if (sts.r_lt_s) begin
					cmd.mul_start = 1'b1;
					st_d = mrpt_pkg::ST_RSQW;
				end else begin
					set_verdict = 1'b1;
					st_d = mrpt_pkg::ST_DONE;
				end
			end
			mrpt_pkg::ST_RSQW: begin
				if (sts.mul_done) st_d = mrpt_pkg::ST_RTEST;
			end
			mrpt_pkg::ST_RTEST: begin
				if (sts.x_nm1) begin
					st_d = mrpt_pkg::ST_NEXTB;
				end else begin
					cmd.r_inc = 1'b1;
					st_d = mrpt_pkg::ST_RCHK;
				end
			end
			mrpt_pkg::ST_NEXTB: begin
				if (sts.base_last) begin
					set_verdict = 1'b1;
					verdict_val = 1'b1;
					st_d = mrpt_pkg::ST_DONE;
				end else begin
					cmd.base_inc = 1'b1;
					st_d = mrpt_pkg::ST_BASE;
				end
			end
			mrpt_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					st_d = mrpt_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = mrpt_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

`ifndef SYNTH
	a_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == mrpt_pkg::ST_IDLE |-> !sts.mul_busy)
		else $error("multiplier busy while idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |=> sts.mul_busy)
		else $error("multiplier did not start");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> st_q == mrpt_pkg::ST_TDIV)
		else $error("accepted transaction not started");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_busy |-> !cmd.mul_start)
		else $error("multiplier started while busy");
`endif

endmodule

// ===== rtl/core/miller_rabin_prime_test_64.sv =====
// deterministic miller-rabin primality test on a 64-bit candidate, one transaction at a time
// the candidate goes through serial trial division, then per base through a modular exponentiation
// and a chain of squarings, all on the single bit-serial modular multiplier; a new candidate is
// taken once the previous verdict is registered; reset clears the controller, counters and
// output valid, data registers are not reset
`timescale 1ns / 1ps
module miller_rabin_prime_test_64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] candidate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_prime
);

	mrpt_pkg::cmd_t cmd;
	mrpt_pkg::sts_t sts;

	// controller: sequences trial division, the d * 2^s split, and the base loop
	mrpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_prime (is_prime),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: operand registers, small-prime remainders and the shared modular multiplier
	// candidate bits above the configured width are dropped here
	mrpt_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cand  (candidate[mrpt_pkg::WIDTH-1:0]),
		.cmd   (cmd),
		.sts   (sts)
	);

endmodule

// ===== tb/sv/prime_checker.sv =====
`timescale 1ns / 1ps
module prime_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] candidate,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        is_prime,
	output int          errors,
	output int          pending
);

	// expected verdicts in order, as a small ring
	localparam int DEPTH = 16;
	logic        verdict_mem [DEPTH];
	logic [63:0] cand_mem [DEPTH];
	int          wr_cnt;
	int          rd_cnt;

	// exact modular product through a full double-width product
	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p % {64'd0, m};
		return p[63:0];
	endfunction

	function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] r;
		logic [63:0] x;
		r = 64'd1 % m;
		x = b % m;
		while (e != 64'd0) begin
			if (e[0])
				r = mul_mod(r, x, m);
			x = mul_mod(x, x, m);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic logic primality(logic [63:0] n);
		logic [63:0] sp[11];
		logic [63:0] bases[7];
		logic [63:0] d;
		logic [63:0] x;
		logic [63:0] nm1;
		int s;
		logic ok;
		sp = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23, 64'd29,
			64'd31};
		bases = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
			64'd1795265022};
		if (n < 64'd2)
			return 1'b0;
		for (int i = 0; i < 11; i++) begin
			if (n == sp[i])
				return 1'b1;
			if (n % sp[i] == 64'd0)
				return 1'b0;
		end
		nm1 = n - 64'd1;
		d = nm1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		for (int i = 0; i < 7; i++) begin
			if (bases[i] % n == 64'd0)
				continue;
			x = pow_mod(bases[i], d, n);
			if (x == 64'd1 || x == nm1)
				continue;
			ok = 1'b0;
			for (int r = 1; r < s; r++) begin
				x = mul_mod(x, x, n);
				if (x == nm1) begin
					ok = 1'b1;
					break;
				end
			end
			if (!ok)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		wr_cnt = 0;
		rd_cnt = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				verdict_mem[wr_cnt % DEPTH] = primality(candidate[mrpt_pkg::WIDTH-1:0]);
				cand_mem[wr_cnt % DEPTH] = candidate;
				wr_cnt++;
			end
			if (out_valid && !out_stall) begin
				if (rd_cnt == wr_cnt)
					report_mismatch("verdict with no candidate outstanding");
				else begin
					if (is_prime !== verdict_mem[rd_cnt % DEPTH])
						report_mismatch($sformatf("candidate %0d: is_prime %b, want %b",
							cand_mem[rd_cnt % DEPTH], is_prime,
							verdict_mem[rd_cnt % DEPTH]));
					rd_cnt++;
				end
			end
			pending = wr_cnt - rd_cnt;
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] candidate;
	logic        out_valid;
	logic        out_stall;
	logic        is_prime;
	int          errors;
	int          pending;

	// per-phase idle and stall odds, in percent
	int send_gap_pct;
	int stall_pct;
	// bumping hold_req asks the receiver for one long hold-off
	int hold_req;

	miller_rabin_prime_test_64 dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
		.out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime)
	);

	prime_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
		.out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls, plus a long counted hold-off on request
	int hold_left;
	int hold_seen;
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		hold_seen = 0;
	end
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 20000;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// one transaction: hold valid until accepted, then maybe drop valid and idle
	task automatic send_candidate(logic [63:0] v);
		in_valid <= 1'b1;
		candidate <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			candidate <= {$urandom, $urandom};
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	// mostly cheap candidates: trial division or the first base settles them
	function automatic logic [63:0] pick_candidate();
		logic [63:0] v;
		case ($urandom_range(9))
			0, 1, 2: v = {$urandom, $urandom};
			3, 4:    v = 64'($urandom_range(0, 5000));
			5:       v = {32'd0, $urandom} | 64'd1;
			6:       v = {$urandom, $urandom} | 64'h8000_0000_0000_0001;
			7:       v = 64'($urandom_range(0, 40)) * 64'd2;
			8:       v = {$urandom, $urandom} * 64'd3;
			default: v = ~64'($urandom_range(0, 300));
		endcase
		return v;
	endfunction

	logic [63:0] directed[$];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		candidate = 64'd0;
		send_gap_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		// zero, one, every small prime, small composites, and 37
		directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17,
			64'd19, 64'd23, 64'd29, 64'd31, 64'd4, 64'd961, 64'd37,
			// prime dividing a base, and a composite that divides one
			64'd73, 64'd14089,
			// strong pseudoprimes to the early bases
			64'd2047, 64'd3215031751, 64'd3825123056546413051,
			// largest 64-bit prime, a mersenne prime, all ones
			64'hFFFF_FFFF_FFFF_FFC5, 64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0000};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_candidate(directed[i]);

		// idle phases: none, sender gaps, receiver stalls, both lightly
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = (ph == 1) ? 46 : (ph == 3) ? 10 : 0;
			stall_pct = (ph == 2) ? 46 : (ph == 3) ? 10 : 0;
			for (int k = 0; k < 66; k++) begin
				// receiver holds off while the sender keeps offering cheap items
				if (ph == 2 && k == 10)
					hold_req = hold_req + 1;
				send_candidate((ph == 2 && k >= 10 && k < 16) ?
					64'($urandom_range(0, 1000)) * 64'd2 : pick_candidate());
			end
			// drain before the next phase
			in_valid <= 1'b0;
			@(posedge clk);
			wait (pending == 0);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#1000ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== miller_rabin_prime_test_64.f =====
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_modmul.sv
rtl/core/mrpt_datapath.sv
rtl/core/mrpt_ctrl.sv
rtl/core/miller_rabin_prime_test_64.sv
tb/sv/prime_checker.sv
tb/sv/testbench.sv
